FILE: hdl/fdm_pkg.sv
// Shared types, constants and drive-type table for the floppy drive mechanism model.
// No dependencies; imported by fdm_eval and floppy_drive_mechanism_model.
package fdm_pkg;

	localparam int TRACK_W    = 7;
	localparam int STEP_W     = 8;
	localparam int TYPE_W     = 4;
	localparam int FLAG_W     = 10;
	localparam int LAST_TRACK = 86;

	localparam int F_RPM300 = 0;
	localparam int F_RPM360 = 1;
	localparam int F_525    = 2;
	localparam int F_HOLE0  = 3;
	localparam int F_HOLE1  = 4;
	localparam int F_HOLE2  = 5;
	localparam int F_DSTEP  = 6;
	localparam int F_INVDS  = 7;
	localparam int F_PS2    = 9;

	typedef enum logic [1:0] {
		REQ_STEP    = 2'd0,
		REQ_FORCE   = 2'd1,
		REQ_DENSITY = 2'd2,
		REQ_HEAD    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		MEDIA_DD = 2'd0,
		MEDIA_HD = 2'd1,
		MEDIA_ED = 2'd2,
		MEDIA_NA = 2'd3
	} media_t;

	typedef enum logic [2:0] {
		REG_DRIVE0 = 3'd0,
		REG_DRIVE1 = 3'd1,
		REG_DRIVE2 = 3'd2,
		REG_DRIVE3 = 3'd3,
		REG_SWAP   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		req_kind_t             kind;
		logic signed [STEP_W-1:0] step;
		logic                  density;
		logic                  head;
		media_t                media;
	} req_t;

	typedef struct packed {
		logic [TRACK_W-1:0] cur_track;
		logic               at_track_zero;
		logic               spin_360;
		logic               media_readable;
		logic               seek_done;
		logic               clear_disk_change;
		logic               cur_head;
		logic               five_inch;
		logic               double_step;
	} res_t;

	function automatic logic [TRACK_W-1:0] type_max(input logic [TYPE_W-1:0] t);
		logic [TRACK_W-1:0] m;
		unique case (t)
			4'd1:                                       m = 7'd43;
			4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: m = 7'd86;
			default:                                    m = 7'd0;
		endcase
		return m;
	endfunction

	function automatic logic [FLAG_W-1:0] type_flags(input logic [TYPE_W-1:0] t);
		logic [FLAG_W-1:0] f;
		f = '0;
		unique case (t)
			4'd1: begin
				f[F_RPM300] = 1'b1; f[F_525] = 1'b1; f[F_HOLE0] = 1'b1;
			end
			4'd2: begin
				f[F_RPM360] = 1'b1; f[F_525] = 1'b1; f[F_HOLE0] = 1'b1;
				f[F_HOLE1] = 1'b1; f[F_DSTEP] = 1'b1;
			end
			4'd3: begin
				f[F_RPM300] = 1'b1; f[F_RPM360] = 1'b1; f[F_525] = 1'b1;
				f[F_HOLE0] = 1'b1; f[F_HOLE1] = 1'b1; f[F_DSTEP] = 1'b1;
			end
			4'd4: begin
				f[F_RPM300] = 1'b1; f[F_HOLE0] = 1'b1; f[F_DSTEP] = 1'b1;
			end
			4'd5: begin
				f[F_RPM300] = 1'b1; f[F_HOLE0] = 1'b1; f[F_HOLE1] = 1'b1;
				f[F_DSTEP] = 1'b1; f[F_INVDS] = 1'b1; f[F_PS2] = 1'b1;
			end
			4'd6: begin
				f[F_RPM300] = 1'b1; f[F_HOLE0] = 1'b1; f[F_HOLE1] = 1'b1;
				f[F_DSTEP] = 1'b1;
			end
			4'd7: begin
				f[F_RPM300] = 1'b1; f[F_RPM360] = 1'b1; f[F_HOLE0] = 1'b1;
				f[F_HOLE1] = 1'b1; f[F_DSTEP] = 1'b1; f[F_INVDS] = 1'b1;
			end
			4'd8: begin
				f[F_RPM300] = 1'b1; f[F_RPM360] = 1'b1; f[F_HOLE0] = 1'b1;
				f[F_HOLE1] = 1'b1; f[F_DSTEP] = 1'b1;
			end
			4'd9: begin
				f[F_RPM300] = 1'b1; f[F_HOLE0] = 1'b1; f[F_HOLE1] = 1'b1;
				f[F_HOLE2] = 1'b1; f[F_DSTEP] = 1'b1;
			end
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

FILE: hdl/floppy_drive_mechanism_model.sv
// Top level of the floppy drive mechanism model: APB registers, request and result stages.
// Depends on fdm_pkg and fdm_eval.
//
//  channel   handshake             payload
//  request   start / busy          req_type drive_sel step_count density_line head_value
//                                  media_density
//  result    done (one cycle)      cur_track at_track_zero spin_360 media_readable seek_done
//                                  clear_disk_change cur_head five_inch double_step
//  config    psel penable pwrite   paddr pwdata prdata pready
//
// One request per cycle; its result shows after the request register and then the result register.
// Rate is set by the single evaluation stage between the request and result registers.
// busy is high from reset until rdy_q is set after reset release; afterwards it stays low.
// Reset clears drive types, swap, tracks, heads and the density line.
// The receiver cannot stall; done lasts exactly one cycle per request.
module floppy_drive_mechanism_model import fdm_pkg::*; #(
	parameter int NUM_DRIVES = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               req_type,
	input  logic [1:0]               drive_sel,
	input  logic signed [STEP_W-1:0] step_count,
	input  logic                     density_line,
	input  logic                     head_value,
	input  logic [1:0]               media_density,
	output logic                     done,
	output logic [TRACK_W-1:0]       cur_track,
	output logic                     at_track_zero,
	output logic                     spin_360,
	output logic                     media_readable,
	output logic                     seek_done,
	output logic                     clear_disk_change,
	output logic                     cur_head,
	output logic                     five_inch,
	output logic                     double_step,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [4:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int IDX_W = (NUM_DRIVES > 2) ? 2 : 1;

	logic [TYPE_W-1:0]  dtype_q [4];
	logic               swap_q;
	logic [TRACK_W-1:0] track_q [NUM_DRIVES];
	logic               head_q  [NUM_DRIVES];
	logic               density_q;
	logic               rdy_q;

	req_t       req_s1;
	logic [1:0] drv_s1;
	logic       present_s1;
	logic       valid_s1;

	res_t res_q;
	logic done_q;

	logic               accept;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;
	logic [1:0]         drv_phys;
	logic [IDX_W-1:0]   idx_s1;
	logic [TRACK_W-1:0] track_nx;
	logic               head_nx;
	logic               density_nx;
	res_t               res_nx;

	assign accept   = start && !busy;
	assign busy     = ~rdy_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = reg_idx_t'(paddr[4:2]);
	assign drv_phys = (swap_q && !drive_sel[1]) ? {drive_sel[1], ~drive_sel[0]} : drive_sel;
	assign idx_s1   = drv_s1[IDX_W-1:0];

	always_comb begin
		unique case (cfg_idx)
			REG_DRIVE0: prdata = {28'd0, dtype_q[0]};
			REG_DRIVE1: prdata = {28'd0, dtype_q[1]};
			REG_DRIVE2: prdata = {28'd0, dtype_q[2]};
			REG_DRIVE3: prdata = {28'd0, dtype_q[3]};
			REG_SWAP:   prdata = {31'd0, swap_q};
			default:    prdata = '0;
		endcase
	end

	fdm_eval u_eval (
		.req        (req_s1),
		.dtype      (dtype_q[drv_s1]),
		.track      (track_q[idx_s1]),
		.head       (head_q[idx_s1]),
		.density    (density_q),
		.track_nx   (track_nx),
		.head_nx    (head_nx),
		.density_nx (density_nx),
		.res        (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) dtype_q[i] <= '0;
			swap_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DRIVE0: dtype_q[0] <= pwdata[TYPE_W-1:0];
				REG_DRIVE1: dtype_q[1] <= pwdata[TYPE_W-1:0];
				REG_DRIVE2: dtype_q[2] <= pwdata[TYPE_W-1:0];
				REG_DRIVE3: dtype_q[3] <= pwdata[TYPE_W-1:0];
				REG_SWAP:   swap_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q      <= 1'b0;
			valid_s1   <= 1'b0;
			present_s1 <= 1'b0;
			drv_s1     <= '0;
		end else begin
			rdy_q    <= 1'b1;
			valid_s1 <= accept;
			if (accept) begin
				drv_s1     <= drv_phys;
				present_s1 <= ({1'b0, drv_phys} < 3'(NUM_DRIVES));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.kind    <= req_kind_t'(req_type);
			req_s1.step    <= step_count;
			req_s1.density <= density_line;
			req_s1.head    <= head_value;
			req_s1.media   <= media_t'(media_density);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DRIVES; i++) begin
				track_q[i] <= '0;
				head_q[i]  <= 1'b0;
			end
			density_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1 && present_s1) begin
				track_q[idx_s1] <= track_nx;
				head_q[idx_s1]  <= head_nx;
				density_q       <= density_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			res_q <= present_s1 ? res_nx : '0;
	end

	assign done              = done_q;
	assign cur_track         = res_q.cur_track;
	assign at_track_zero     = res_q.at_track_zero;
	assign spin_360          = res_q.spin_360;
	assign media_readable    = res_q.media_readable;
	assign seek_done         = res_q.seek_done;
	assign clear_disk_change = res_q.clear_disk_change;
	assign cur_head          = res_q.cur_head;
	assign five_inch         = res_q.five_inch;
	assign double_step       = res_q.double_step;

	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request did not reach the evaluation stage");

	a_s1_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("evaluated request produced no result strobe");

	a_clear_needs_seek: assert property (@(posedge clk) disable iff (!arst_n)
		done && clear_disk_change |-> seek_done)
		else $error("disk-change clear without a seek");

	a_trk0_track: assert property (@(posedge clk) disable iff (!arst_n)
		done && at_track_zero |-> cur_track == '0)
		else $error("TRK0 reported away from track zero");

	a_track_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done && seek_done |-> cur_track <= TRACK_W'(LAST_TRACK))
		else $error("seek left the head beyond the last track");

endmodule

FILE: hdl/fdm_eval.sv
// Request evaluation for one drive: seek clamp, head and density update, result flags.
// Depends on fdm_pkg for the request/result types and the drive-type table.
module fdm_eval import fdm_pkg::*; (
	input  req_t               req,
	input  logic [TYPE_W-1:0]  dtype,
	input  logic [TRACK_W-1:0] track,
	input  logic               head,
	input  logic               density,
	output logic [TRACK_W-1:0] track_nx,
	output logic               head_nx,
	output logic               density_nx,
	output res_t               res
);

	logic [FLAG_W-1:0]        flags;
	logic [TRACK_W-1:0]       maxt;
	logic signed [TRACK_W+1:0] sum;
	logic                     do_seek;
	logic                     rpm;
	logic                     readable;

	always_comb begin
		flags   = type_flags(dtype);
		maxt    = type_max(dtype);
		sum     = $signed({2'b00, track}) + $signed({req.step[STEP_W-1], req.step});
		do_seek = (req.kind == REQ_FORCE) || ((req.kind == REQ_STEP) && (req.step != '0));

		track_nx = track;
		if (do_seek) begin
			priority if (sum < 0)
				track_nx = '0;
			else if (sum > $signed({2'b00, maxt}))
				track_nx = maxt;
			else
				track_nx = sum[TRACK_W-1:0];
		end
		head_nx    = (req.kind == REQ_HEAD) ? req.head : head;
		density_nx = (req.kind == REQ_DENSITY) ? req.density : density;

		priority if (!flags[F_RPM360])
			rpm = 1'b0;
		else if (!flags[F_RPM300])
			rpm = 1'b1;
		else if (flags[F_525])
			rpm = density_nx;
		else if (req.media == MEDIA_HD)
			rpm = ~density_nx;
		else
			rpm = 1'b0;

		unique case (req.media)
			MEDIA_DD: readable = flags[F_HOLE0];
			MEDIA_HD: readable = flags[F_HOLE1];
			MEDIA_ED: readable = flags[F_HOLE2];
			default:  readable = 1'b0;
		endcase

		res.cur_track         = track_nx;
		res.at_track_zero     = (maxt != '0) && (track_nx == '0);
		res.spin_360          = rpm;
		res.media_readable    = readable;
		res.seek_done         = do_seek;
		res.clear_disk_change = do_seek && (req.kind == REQ_STEP);
		res.cur_head          = head_nx;
		res.five_inch         = flags[F_525];
		res.double_step       = flags[F_DSTEP];
	end

endmodule

FILE: tb/tb.sv
// Self-checking bench for floppy_drive_mechanism_model: drive requests, APB register setup,
// and an in-order predictor of track, TRK0, rpm, media, head and seek results per drive.
// Depends on fdm_pkg and the floppy_drive_mechanism_model RTL.
module tb;
	import fdm_pkg::*;

	typedef struct {
		req_kind_t          kind;
		logic [1:0]         drv;
		logic signed [7:0]  step;
		logic               dens;
		logic               head;
		media_t             media;
	} drive_cmd_t;

	typedef struct packed {
		logic [TRACK_W-1:0] max_trk;
		logic               rpm300;
		logic               rpm360;
		logic               is525;
		logic [2:0]         holes;
		logic               dstep;
	} drive_caps_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] req_type = '0;
	logic [1:0] drive_sel = '0;
	logic signed [STEP_W-1:0] step_count = '0;
	logic density_line = 1'b0;
	logic head_value = 1'b0;
	logic [1:0] media_density = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic busy, done, at_track_zero, spin_360, media_readable, seek_done;
	logic clear_disk_change, cur_head, five_inch, double_step, pready;
	logic [TRACK_W-1:0] cur_track;
	logic [31:0] prdata;

	drive_cmd_t drive_cmds[$];
	res_t status_due[$];
	logic [TYPE_W-1:0] type_cfg[4];
	logic swap_cfg;
	logic [TRACK_W-1:0] trk_state[4];
	logic head_state[4];
	logic dens_state;
	int idle_pct = 25;
	logic drain = 1'b0;
	int issued = 0;
	int reqs_taken = 0;
	int results_seen = 0;
	int settings_done = 0;
	int errors = 0;

	floppy_drive_mechanism_model dut (.*);

	always #10 clk = ~clk;

	function automatic drive_caps_t caps_of(input logic [TYPE_W-1:0] t);
		case (t)
			4'd1: return '{7'd43, 1'b1, 1'b0, 1'b1, 3'b001, 1'b0};
			4'd2: return '{7'd86, 1'b0, 1'b1, 1'b1, 3'b011, 1'b1};
			4'd3: return '{7'd86, 1'b1, 1'b1, 1'b1, 3'b011, 1'b1};
			4'd4: return '{7'd86, 1'b1, 1'b0, 1'b0, 3'b001, 1'b1};
			4'd5, 4'd6: return '{7'd86, 1'b1, 1'b0, 1'b0, 3'b011, 1'b1};
			4'd7, 4'd8: return '{7'd86, 1'b1, 1'b1, 1'b0, 3'b011, 1'b1};
			4'd9: return '{7'd86, 1'b1, 1'b0, 1'b0, 3'b111, 1'b1};
			default: return '0;
		endcase
	endfunction

	function automatic res_t drive_status_after(input drive_cmd_t c);
		res_t r;
		drive_caps_t cap;
		int d;
		int nt;
		r = '0;
		d = c.drv;
		if (swap_cfg && d < 2) d = d ^ 1;
		cap = caps_of(type_cfg[d]);
		if (c.kind == REQ_STEP || c.kind == REQ_FORCE) begin
			if (c.kind == REQ_FORCE || c.step != 0) begin
				nt = int'(trk_state[d]) + int'(c.step);
				if (nt < 0) nt = 0;
				if (nt > int'(cap.max_trk)) nt = int'(cap.max_trk);
				trk_state[d] = nt[TRACK_W-1:0];
				r.seek_done = 1'b1;
				r.clear_disk_change = (c.kind == REQ_STEP);
			end
		end else if (c.kind == REQ_DENSITY) begin
			dens_state = c.dens;
		end else begin
			head_state[d] = c.head;
		end
		if (!cap.rpm360) r.spin_360 = 1'b0;
		else if (!cap.rpm300) r.spin_360 = 1'b1;
		else if (cap.is525) r.spin_360 = dens_state;
		else if (c.media == MEDIA_HD) r.spin_360 = !dens_state;
		else r.spin_360 = 1'b0;
		r.media_readable = (c.media != MEDIA_NA) && cap.holes[c.media];
		r.cur_track = trk_state[d];
		r.at_track_zero = (cap.max_trk != 0) && (trk_state[d] == 0);
		r.cur_head = head_state[d];
		r.five_inch = cap.is525;
		r.double_step = cap.dstep;
		return r;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		drive_cmd_t c;
		res_t e;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (status_due.size() == 0) begin
					$error("result with no request outstanding, track %0d", cur_track);
					errors++;
				end else begin
					e = status_due.pop_front();
					check_field("cur_track", e.cur_track, cur_track);
					check_field("at_track_zero", e.at_track_zero, at_track_zero);
					check_field("spin_360", e.spin_360, spin_360);
					check_field("media_readable", e.media_readable, media_readable);
					check_field("seek_done", e.seek_done, seek_done);
					check_field("clear_disk_change", e.clear_disk_change, clear_disk_change);
					check_field("cur_head", e.cur_head, cur_head);
					check_field("five_inch", e.five_inch, five_inch);
					check_field("double_step", e.double_step, double_step);
				end
			end
			if (start && !busy) begin
				c.kind = req_kind_t'(req_type);
				c.drv = drive_sel;
				c.step = step_count;
				c.dens = density_line;
				c.head = head_value;
				c.media = media_t'(media_density);
				status_due.push_back(drive_status_after(c));
				reqs_taken++;
			end
		end
	end

	always @(posedge clk) begin
		drive_cmd_t c;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (drain) begin
			if (status_due.size() == 0) drain <= 1'b0;
		end else if (!start || !busy) begin
			if (start && issued % 75 == 0) begin
				drain <= 1'b1;
				start <= 1'b0;
			end else if (drive_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
				c = drive_cmds.pop_front();
				start <= 1'b1;
				req_type <= c.kind;
				drive_sel <= c.drv;
				step_count <= c.step;
				density_line <= c.dens;
				head_value <= c.head;
				media_density <= c.media;
				issued <= issued + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic push_cmd(input req_kind_t k, input logic [1:0] d, input int s,
			input logic dn, input logic hd, input media_t m);
		drive_cmd_t c;
		c.kind = k;
		c.drv = d;
		c.step = s[7:0];
		c.dens = dn;
		c.head = hd;
		c.media = m;
		drive_cmds.push_back(c);
	endtask

	task automatic push_random(input int n);
		int r;
		int s;
		repeat (n) begin
			r = $urandom_range(9);
			case ($urandom_range(9))
				0: s = 0;
				1: s = -128;
				2: s = 127;
				3, 4, 5, 6: s = int'($urandom_range(16)) - 8;
				default: s = int'($urandom_range(255)) - 128;
			endcase
			push_cmd(r < 4 ? REQ_STEP : r < 6 ? REQ_FORCE : r < 8 ? REQ_DENSITY : REQ_HEAD,
				$urandom_range(3), s, $urandom_range(1), $urandom_range(1),
				media_t'($urandom_range(3)));
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (drive_cmds.size() != 0 || start || drain || status_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_SWAP) swap_cfg = val[0];
		else type_cfg[idx] = val[TYPE_W-1:0];
	endtask

	task automatic set_drives(input int t0, input int t1, input int t2, input int t3,
			input logic sw);
		wait_idle();
		apb_write(REG_DRIVE0, t0);
		apb_write(REG_DRIVE1, t1);
		apb_write(REG_DRIVE2, t2);
		apb_write(REG_DRIVE3, t3);
		apb_write(REG_SWAP, sw);
		settings_done++;
		@(negedge clk);
	endtask

	initial begin
		#(200000 * 20);
		$display("FAIL floppy_drive_mechanism_model");
		$finish;
	end

	initial begin
		for (int i = 0; i < 4; i++) begin
			type_cfg[i] = '0;
			trk_state[i] = '0;
			head_state[i] = 1'b0;
		end
		swap_cfg = 1'b0;
		dens_state = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_drives(1, 2, 5, 9, 1'b0);
		push_cmd(REQ_STEP, 0, 127, 0, 0, MEDIA_DD);
		push_cmd(REQ_STEP, 0, -128, 0, 0, MEDIA_DD);
		push_cmd(REQ_STEP, 0, 0, 0, 0, MEDIA_HD);
		push_cmd(REQ_FORCE, 0, 0, 0, 0, MEDIA_DD);
		push_cmd(REQ_FORCE, 1, 127, 0, 0, MEDIA_HD);
		push_cmd(REQ_DENSITY, 1, 0, 1, 0, MEDIA_HD);
		push_cmd(REQ_HEAD, 2, 0, 0, 1, MEDIA_HD);
		push_cmd(REQ_HEAD, 3, 0, 0, 1, MEDIA_ED);
		push_cmd(REQ_STEP, 3, -1, 0, 0, MEDIA_NA);
		push_cmd(REQ_STEP, 2, 5, 0, 0, MEDIA_ED);
		push_cmd(REQ_DENSITY, 0, 0, 0, 0, MEDIA_DD);
		push_cmd(REQ_HEAD, 2, 0, 0, 0, MEDIA_DD);
		push_cmd(REQ_STEP, 1, -43, 0, 0, MEDIA_DD);
		push_cmd(REQ_FORCE, 3, -128, 0, 0, MEDIA_NA);

		set_drives(3, 7, 8, 0, 1'b1);
		push_cmd(REQ_DENSITY, 0, 0, 1, 0, MEDIA_HD);
		push_cmd(REQ_STEP, 1, 3, 0, 0, MEDIA_HD);
		push_cmd(REQ_DENSITY, 2, 0, 0, 0, MEDIA_HD);
		push_cmd(REQ_STEP, 2, 2, 0, 0, MEDIA_DD);
		push_cmd(REQ_HEAD, 3, 0, 0, 1, MEDIA_DD);
		push_cmd(REQ_STEP, 3, 9, 0, 0, MEDIA_ED);
		push_cmd(REQ_FORCE, 0, 0, 0, 0, MEDIA_NA);
		push_cmd(REQ_STEP, 1, 127, 0, 0, MEDIA_ED);

		set_drives(1, 15, 4, 6, 1'b0);
		push_cmd(REQ_HEAD, 0, 0, 0, 0, MEDIA_DD);
		push_cmd(REQ_STEP, 0, -1, 0, 0, MEDIA_DD);
		push_random(130);

		wait_idle();
		idle_pct = 88;
		set_drives(9, 10, 2, 3, 1'b1);
		push_random(130);

		wait_idle();
		idle_pct = 0;
		set_drives(0, 8, 9, 15, 1'b0);
		push_random(130);

		wait_idle();
		$display("Checked %0d results for %0d requests across %0d drive/swap settings.",
			results_seen, reqs_taken, settings_done);
		if (errors == 0) begin
			$display("PASS floppy_drive_mechanism_model");
		end else begin
			$display("FAIL floppy_drive_mechanism_model");
		end
		$finish;
	end

endmodule

FILE: floppy_drive_mechanism_model.f
hdl/fdm_pkg.sv
hdl/fdm_eval.sv
hdl/floppy_drive_mechanism_model.sv
tb/tb.sv
